// ===== src/eihp_pkg.sv =====
// ----------------------------------------------------------------------------
// Ethernet/IPv4 header parser package
// Shared payload types, constants and one's-complement helper.
// ----------------------------------------------------------------------------
package eihp_pkg;

  localparam int unsigned MaxFrameBytes = 2048;
  localparam int unsigned PosW = $clog2(MaxFrameBytes + 1);

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeArp  = 16'h0806;
  localparam logic [7:0]  ProtoIcmp = 8'd1;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;

  localparam logic [1:0] EkUnknown = 2'd0;
  localparam logic [1:0] EkIpv4    = 2'd1;
  localparam logic [1:0] EkArp     = 2'd2;
  localparam logic [1:0] LkOther   = 2'd0;
  localparam logic [1:0] LkIcmp    = 2'd1;
  localparam logic [1:0] LkTcp     = 2'd2;
  localparam logic [1:0] LkUdp     = 2'd3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  ether_kind;
    logic [1:0]  l4_kind;
    logic        ip_header_ok;
    logic        tcp_checksum_ok;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [3:0]  tcp_flag_bits;
    logic [15:0] window_size;
    logic        arp_request;
    logic [7:0]  icmp_type;
  } out_item_t;

  // raw per-frame summary handed from the byte front end to the result stage
  typedef struct packed {
    logic [15:0] frame_type;
    logic [7:0]  protocol;
    logic [15:0] ip_sum;
    logic [15:0] tcp_sum;
    logic [15:0] seg_len;
    logic [31:0] ports;
    logic [63:0] seq_ack;
    logic [19:0] flags_win;
    logic        arp_req;
    logic [7:0]  icmp;
  } summary_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== src/eihp_front.sv =====
// ----------------------------------------------------------------------------
// Byte front end
// Tracks byte offset, captures header fields and runs both running sums.
// ----------------------------------------------------------------------------
module eihp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  eihp_pkg::in_item_t  item,
  output logic                done,
  output eihp_pkg::summary_t  summary
);

  logic [eihp_pkg::PosW-1:0] pos_r;
  logic [15:0] ftype_r, tlen_r, ipsum_r, tcpsum_r, lead_r;
  logic [5:0]  hlen_r;
  logic [7:0]  proto_r, pend_r, icmp_r;
  logic [31:0] ports_r;
  logic [63:0] seqack_r;
  logic [19:0] fw_r;
  logic        arp_r;

  logic [eihp_pkg::PosW-1:0] pos_nxt;
  logic [15:0] ftype_nxt, tlen_nxt, ipsum_nxt, tcpsum_nxt, lead_nxt;
  logic [5:0]  hlen_nxt;
  logic [7:0]  proto_nxt, pend_nxt, icmp_nxt;
  logic [31:0] ports_nxt;
  logic [63:0] seqack_nxt;
  logic [19:0] fw_nxt;
  logic        arp_nxt;

  logic [15:0] p, word, seglen, s, o, n;
  logic [7:0]  b;
  logic        odd, last, inrange;

  always_comb begin
    pos_nxt = pos_r; ftype_nxt = ftype_r; tlen_nxt = tlen_r; ipsum_nxt = ipsum_r;
    tcpsum_nxt = tcpsum_r; lead_nxt = lead_r; hlen_nxt = hlen_r; proto_nxt = proto_r;
    pend_nxt = pend_r; icmp_nxt = icmp_r; ports_nxt = ports_r; seqack_nxt = seqack_r;
    fw_nxt = fw_r; arp_nxt = arp_r;
    b = item.frame_byte; last = item.last_byte;
    p = 16'(pos_r);
    odd = p[0];
    word = odd ? {pend_r, b} : {b, 8'd0};
    inrange = 32'(pos_r) < eihp_pkg::MaxFrameBytes;
    seglen = '0; s = '0; o = '0; n = '0;
    if (inrange) begin
      pos_nxt = pos_r + 1'b1;
      if (p == 16'd12) ftype_nxt[15:8] = b;
      if (p == 16'd13) ftype_nxt[7:0] = b;
      if (p == 16'd14) hlen_nxt = {b[3:0], 2'b00};
      if (p == 16'd16) tlen_nxt[15:8] = b;
      if (p == 16'd17) tlen_nxt[7:0] = b;
      if (p == 16'd21) arp_nxt = (b == 8'd1);
      if (p == 16'd23) proto_nxt = b;
      seglen = tlen_nxt - {10'd0, hlen_nxt};
      s = 16'd14 + {10'd0, hlen_nxt};
      if (p >= 16'd14 && p < s && (odd || last)) ipsum_nxt = eihp_pkg::oc_add(ipsum_r, word);
      if (p >= 16'd26 && p <= 16'd33 && (odd || last))
        tcpsum_nxt = eihp_pkg::oc_add(tcpsum_nxt, word);
      // segment end compared in 17 bits: s plus length can pass 65535
      if (p >= 16'd18 && p >= s && ({1'b0, p} < ({1'b0, s} + {1'b0, seglen}))
          && (odd || last || ({1'b0, p} + 17'd1 == {1'b0, s} + {1'b0, seglen})))
        tcpsum_nxt = eihp_pkg::oc_add(tcpsum_nxt, word);
      if (p == 16'd15) lead_nxt = word;
      if (hlen_nxt == 6'd0 && p >= 16'd14 && p <= 16'd17 && (p == 16'd17 || last)) begin
        n = seglen;
        if (n >= 16'd2) tcpsum_nxt = eihp_pkg::oc_add(tcpsum_nxt, lead_nxt);
        else if (n == 16'd1) tcpsum_nxt = eihp_pkg::oc_add(tcpsum_nxt, {lead_nxt[15:8], 8'd0});
        if (n >= 16'd4) tcpsum_nxt = eihp_pkg::oc_add(tcpsum_nxt, tlen_nxt);
        else if (n == 16'd3) tcpsum_nxt = eihp_pkg::oc_add(tcpsum_nxt, {tlen_nxt[15:8], 8'd0});
      end
      o = p - s;
      if (p >= 16'd14 && p >= s && o < 16'd16) begin
        case (o[3:0])
          4'd0:  ports_nxt[31:24] = b;
          4'd1:  ports_nxt[23:16] = b;
          4'd2:  ports_nxt[15:8]  = b;
          4'd3:  ports_nxt[7:0]   = b;
          4'd4:  seqack_nxt[63:56] = b;
          4'd5:  seqack_nxt[55:48] = b;
          4'd6:  seqack_nxt[47:40] = b;
          4'd7:  seqack_nxt[39:32] = b;
          4'd8:  seqack_nxt[31:24] = b;
          4'd9:  seqack_nxt[23:16] = b;
          4'd10: seqack_nxt[15:8]  = b;
          4'd11: seqack_nxt[7:0]   = b;
          4'd13: fw_nxt[19:16] = {b[4], b[2], b[1], b[0]};
          4'd14: fw_nxt[15:8] = b;
          4'd15: fw_nxt[7:0] = b;
          default: ;
        endcase
        if (o == 16'd0) icmp_nxt = b;
      end
      if (!odd) pend_nxt = b;
    end
    summary.frame_type = ftype_nxt;
    summary.protocol   = proto_nxt;
    summary.ip_sum     = ipsum_nxt;
    summary.tcp_sum    = tcpsum_nxt;
    summary.seg_len    = tlen_nxt - {10'd0, hlen_nxt};
    summary.ports      = ports_nxt;
    summary.seq_ack    = seqack_nxt;
    summary.flags_win  = fw_nxt;
    summary.arp_req    = arp_nxt;
    summary.icmp       = icmp_nxt;
  end

  assign done = take && last;

  always_ff @(posedge clk) begin
    if (!rst_n || done) begin
      pos_r <= '0; ftype_r <= '0; tlen_r <= '0; ipsum_r <= '0; tcpsum_r <= '0;
      lead_r <= '0; hlen_r <= '0; proto_r <= '0; pend_r <= '0; icmp_r <= '0;
      ports_r <= '0; seqack_r <= '0; fw_r <= '0; arp_r <= 1'b0;
    end else if (take) begin
      pos_r <= pos_nxt; ftype_r <= ftype_nxt; tlen_r <= tlen_nxt; ipsum_r <= ipsum_nxt;
      tcpsum_r <= tcpsum_nxt; lead_r <= lead_nxt; hlen_r <= hlen_nxt; proto_r <= proto_nxt;
      pend_r <= pend_nxt; icmp_r <= icmp_nxt; ports_r <= ports_nxt; seqack_r <= seqack_nxt;
      fw_r <= fw_nxt; arp_r <= arp_nxt;
    end
  end

endmodule

// ===== src/eihp_queue.sv =====
// ----------------------------------------------------------------------------
// Summary queue
// Two-entry queue of frame summaries between front end and result stage.
// ----------------------------------------------------------------------------
module eihp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr,
  input  eihp_pkg::summary_t wdata,
  output logic               full,
  input  logic               rd,
  output logic               empty,
  output eihp_pkg::summary_t rdata
);

  eihp_pkg::summary_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr && !full) wp_r <= ~wp_r;
      if (rd && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr && !full} - {1'b0, rd && !empty};
    end
  end

endmodule

// ===== src/eihp_back.sv =====
// ----------------------------------------------------------------------------
// Result stage
// Classifies a frame summary and gates the fields into a result.
// ----------------------------------------------------------------------------
module eihp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  eihp_pkg::summary_t  q_data,
  output logic                q_rd,
  output logic                empty,
  input  logic                pop,
  output eihp_pkg::out_item_t data
);

  eihp_pkg::out_item_t res_r, res_nxt;
  logic        valid_r;
  logic [15:0] t;

  assign q_rd  = !q_empty && (!valid_r || pop);
  assign empty = !valid_r;
  assign data  = res_r;

  always_comb begin
    res_nxt = '0;
    t = eihp_pkg::oc_add(eihp_pkg::oc_add(q_data.tcp_sum, 16'h0006), q_data.seg_len);
    if (q_data.frame_type == eihp_pkg::EtypeIpv4) begin
      res_nxt.ether_kind = eihp_pkg::EkIpv4;
      case (q_data.protocol)
        eihp_pkg::ProtoIcmp: res_nxt.l4_kind = eihp_pkg::LkIcmp;
        eihp_pkg::ProtoTcp:  res_nxt.l4_kind = eihp_pkg::LkTcp;
        eihp_pkg::ProtoUdp:  res_nxt.l4_kind = eihp_pkg::LkUdp;
        default:             res_nxt.l4_kind = eihp_pkg::LkOther;
      endcase
      res_nxt.ip_header_ok = q_data.ip_sum == 16'hFFFF;
      if (res_nxt.l4_kind == eihp_pkg::LkTcp) begin
        res_nxt.tcp_checksum_ok = t == 16'hFFFF;
        res_nxt.sequence_number = q_data.seq_ack[63:32];
        res_nxt.tcp_flag_bits   = q_data.flags_win[19:16];
        res_nxt.ack_number      = q_data.flags_win[19] ? q_data.seq_ack[31:0] : 32'd0;
        res_nxt.window_size     = q_data.flags_win[15:0];
      end
      if (res_nxt.l4_kind == eihp_pkg::LkTcp || res_nxt.l4_kind == eihp_pkg::LkUdp) begin
        res_nxt.source_port = q_data.ports[31:16];
        res_nxt.dest_port   = q_data.ports[15:0];
      end
      if (res_nxt.l4_kind == eihp_pkg::LkIcmp) res_nxt.icmp_type = q_data.icmp;
    end else if (q_data.frame_type == eihp_pkg::EtypeArp) begin
      res_nxt.ether_kind  = eihp_pkg::EkArp;
      res_nxt.arp_request = q_data.arp_req;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (q_rd) valid_r <= 1'b1;
    else if (pop) valid_r <= 1'b0;
  end

endmodule

// ===== src/ethernet_ipv4_header_parser.sv =====
// ----------------------------------------------------------------------------
// Ethernet/IPv4 header parser
// Streams a frame byte by byte and gives one summary request per frame.
// ----------------------------------------------------------------------------
// Push one frame byte per cycle, first destination-MAC byte first, and mark
// the final byte with last_byte; a final byte waits while in_full is high.
// On the last byte the front end hands a frame summary to a two-entry queue,
// and the result stage turns it into a classified result held in an output
// register until popped. The summary is written into the queue as the last
// byte is accepted, and the output register loads it from the queue when it
// is empty or being popped. full rises only when the queue and the output
// register are both occupied and another frame ends; bytes of a following
// frame keep flowing meanwhile.
// Bytes past the maximum frame length are dropped; absent fields read zero.
module ethernet_ipv4_header_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  eihp_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output eihp_pkg::out_item_t out_data
);

  logic               take, done, q_full, q_empty, q_rd;
  eihp_pkg::summary_t summary, q_data;

  // hold off only a final byte that has nowhere to go
  assign in_full = q_full && in_data.last_byte;
  assign take    = in_push && !in_full;

  eihp_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .item(in_data),
    .done(done), .summary(summary)
  );

  eihp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr(done), .wdata(summary), .full(q_full),
    .rd(q_rd), .empty(q_empty), .rdata(q_data)
  );

  eihp_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data), .q_rd(q_rd),
    .empty(out_empty), .pop(out_pop), .data(out_data)
  );

endmodule

// ===== src/eihp_checker.sv =====
// ----------------------------------------------------------------------------
// Parser port checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module eihp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input eihp_pkg::in_item_t  in_data,
  input logic                out_empty,
  input logic                out_pop,
  input eihp_pkg::out_item_t out_data
);

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result changed while waiting");

  a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> in_data.last_byte)
    else $error("full raised for a non-final byte");

  a_arp_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.ether_kind != eihp_pkg::EkIpv4) |->
      (out_data.l4_kind == eihp_pkg::LkOther && !out_data.ip_header_ok))
    else $error("l4 fields on a non-IPv4 result");

  // the summary goes into the queue, then into the output register; a held result keeps out_empty low
  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_data.last_byte) |-> ##2 !out_empty)
    else $error("frame end gave no result");

endmodule

bind ethernet_ipv4_header_parser eihp_checker u_checker (.*);

// ===== tb/tb_ethernet_ipv4_header_parser.sv =====
// ----------------------------------------------------------------------------
// Ethernet/IPv4 header parser testbench
// Streams directed and random frames through the parser, predicts each frame
// summary in a scoreboard and checks every popped request field by field.
// ----------------------------------------------------------------------------
module tb_ethernet_ipv4_header_parser;
  import eihp_pkg::*;

  // Frame summary predictor and store of expected requests.
  class frame_scoreboard;
    int unsigned pos;
    logic [15:0] etype;
    logic [5:0]  hdr_len;
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic [15:0] ip_sum;
    logic [15:0] seg_sum;
    logic [7:0]  hi_byte;
    logic [31:0] ports;
    logic [63:0] seq_ack;
    logic [19:0] flags_win;
    logic        arp_req;
    logic [7:0]  icmp;
    logic [15:0] lead;
    out_item_t   pending_q[$];
    int          errors;

    function void clear_frame();
      pos = 0; etype = '0; hdr_len = '0; tot_len = '0; proto = '0;
      ip_sum = '0; seg_sum = '0; hi_byte = '0; ports = '0; seq_ack = '0;
      flags_win = '0; arp_req = 1'b0; icmp = '0; lead = '0;
    endfunction

    function logic [15:0] ones_add(logic [15:0] a, logic [15:0] w);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, w};
      return s[15:0] + {15'd0, s[16]};
    endfunction

    function logic [15:0] seg_len();
      return tot_len - {10'd0, hdr_len};
    endfunction

    function void take(int unsigned p, logic [7:0] b, bit last);
      bit          odd;
      logic [15:0] word;
      int unsigned s, e, o, n;
      odd  = p[0];
      word = odd ? {hi_byte, b} : {b, 8'h00};
      if (p == 12) etype[15:8] = b;
      if (p == 13) etype[7:0] = b;
      if (p == 14) hdr_len = {b[3:0], 2'b00};
      if (p == 16) tot_len[15:8] = b;
      if (p == 17) tot_len[7:0] = b;
      if (p == 21) arp_req = (b == 8'd1);
      if (p == 23) proto = b;
      s = 14 + hdr_len;
      e = s + seg_len();
      if (p >= 14 && p < s && (odd || last)) ip_sum = ones_add(ip_sum, word);
      if (p >= 26 && p <= 33 && (odd || last)) seg_sum = ones_add(seg_sum, word);
      if (p >= 18 && p >= s && p < e && (odd || last || p + 1 == e))
        seg_sum = ones_add(seg_sum, word);
      if (p == 15) lead = word;
      // zero header length: the segment overlaps bytes 14-17
      if (hdr_len == 0 && p >= 14 && p <= 17 && (p == 17 || last)) begin
        n = seg_len();
        if (n >= 2) seg_sum = ones_add(seg_sum, lead);
        else if (n == 1) seg_sum = ones_add(seg_sum, lead & 16'hFF00);
        if (n >= 4) seg_sum = ones_add(seg_sum, tot_len);
        else if (n == 3) seg_sum = ones_add(seg_sum, tot_len & 16'hFF00);
      end
      if (p >= 14 && p >= s && p - s < 16) begin
        o = p - s;
        if (o < 4) ports[(3 - o) * 8 +: 8] = b;
        else if (o < 12) seq_ack[(11 - o) * 8 +: 8] = b;
        else if (o == 13) flags_win[19:16] = {b[4], b[2], b[1], b[0]};
        else if (o == 14) flags_win[15:8] = b;
        else if (o == 15) flags_win[7:0] = b;
        if (o == 0) icmp = b;
      end
      if (!odd) hi_byte = b;
    endfunction

    // Note an accepted byte; queue the summary on a last byte.
    function void note_byte(in_item_t it);
      out_item_t   r;
      logic [15:0] t;
      if (pos < MaxFrameBytes) begin
        take(pos, it.frame_byte, it.last_byte);
        pos++;
      end
      if (!it.last_byte) return;
      r = '0;
      if (etype == EtypeIpv4) r.ether_kind = EkIpv4;
      else if (etype == EtypeArp) r.ether_kind = EkArp;
      if (r.ether_kind == EkIpv4) begin
        if (proto == ProtoIcmp) r.l4_kind = LkIcmp;
        else if (proto == ProtoTcp) r.l4_kind = LkTcp;
        else if (proto == ProtoUdp) r.l4_kind = LkUdp;
        r.ip_header_ok = (ip_sum == 16'hFFFF);
        t = ones_add(ones_add(seg_sum, 16'h0006), seg_len());
        if (r.l4_kind == LkTcp) begin
          r.tcp_checksum_ok = (t == 16'hFFFF);
          r.sequence_number = seq_ack[63:32];
          r.tcp_flag_bits   = flags_win[19:16];
          r.ack_number      = flags_win[19] ? seq_ack[31:0] : 32'd0;
          r.window_size     = flags_win[15:0];
        end
        if (r.l4_kind == LkTcp || r.l4_kind == LkUdp) begin
          r.source_port = ports[31:16];
          r.dest_port   = ports[15:0];
        end
        if (r.l4_kind == LkIcmp) r.icmp_type = icmp;
      end else if (r.ether_kind == EkArp) begin
        r.arp_request = arp_req;
      end
      pending_q.push_back(r);
      clear_frame();
    endfunction

    function void check_field(string nm, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", nm, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_summary(out_item_t got);
      out_item_t w;
      if (pending_q.size() == 0) begin
        $error("request popped with none expected");
        errors++;
        return;
      end
      w = pending_q.pop_front();
      check_field("ether_kind", w.ether_kind, got.ether_kind);
      check_field("l4_kind", w.l4_kind, got.l4_kind);
      check_field("ip_header_ok", w.ip_header_ok, got.ip_header_ok);
      check_field("tcp_checksum_ok", w.tcp_checksum_ok, got.tcp_checksum_ok);
      check_field("source_port", w.source_port, got.source_port);
      check_field("dest_port", w.dest_port, got.dest_port);
      check_field("sequence_number", w.sequence_number, got.sequence_number);
      check_field("ack_number", w.ack_number, got.ack_number);
      check_field("tcp_flag_bits", w.tcp_flag_bits, got.tcp_flag_bits);
      check_field("window_size", w.window_size, got.window_size);
      check_field("arp_request", w.arp_request, got.arp_request);
      check_field("icmp_type", w.icmp_type, got.icmp_type);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_data = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_data;

  frame_scoreboard sb = new();
  logic [7:0] frame_buf[$];
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  bit hold_pop = 1'b0;

  localparam int unsigned CycleLimit = 1_000_000;

  ethernet_ipv4_header_parser dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .out_empty(out_empty), .out_pop(out_pop),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Timeout guard: generous next to the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL ethernet_ipv4_header_parser");
      $finish;
    end
  end

  // Observe both handshakes at the edge, before the drivers move.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) sb.note_byte(in_data);
    if (rst_n && out_pop && !out_empty) sb.check_summary(out_data);
  end

  // Receiver: own stall pattern, plus a long hold-off when asked.
  always @(posedge clk) begin
    int unsigned ph;
    ph = cycle_count % 37;
    if (!rst_n || hold_pop) out_pop <= 1'b0;
    else if (ph < 12) out_pop <= 1'b1;
    else if (ph < 20) out_pop <= 1'b0;
    else out_pop <= ($urandom_range(0, 3) != 0);
  end

  // Push every byte of frame_buf, bursts with random gaps between them.
  task automatic send_frame();
    int burst;
    burst = $urandom_range(1, 40);
    for (int i = 0; i < frame_buf.size(); i++) begin
      if (burst == 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = $urandom_range(1, 40);
      end
      in_push <= 1'b1;
      in_data <= '{frame_byte: frame_buf[i], last_byte: (i == frame_buf.size() - 1)};
      @(posedge clk);
      while (in_full) @(posedge clk);
      burst--;
      bytes_sent++;
    end
    in_push <= 1'b0;
  endtask

  function automatic void put16(int unsigned at, logic [15:0] v);
    frame_buf[at]     = v[15:8];
    frame_buf[at + 1] = v[7:0];
  endfunction

  // Fold a checksum over frame_buf[from +: len] and return its complement.
  function automatic logic [15:0] csum(int unsigned from, int unsigned len,
                                       logic [31:0] pre);
    logic [31:0] acc;
    acc = pre;
    for (int unsigned i = 0; i < len; i += 2)
      acc += {frame_buf[from + i], (i + 1 < len) ? frame_buf[from + i + 1] : 8'h00};
    while (acc[31:16] != 0) acc = acc[15:0] + acc[31:16];
    return ~acc[15:0];
  endfunction

  // Build a well-formed frame with random content; corrupt it now and then.
  function automatic void build_frame(int kind, int unsigned seg_n, bit good);
    int unsigned ihl, hl, total;
    logic [7:0] proto;
    logic [31:0] pre;
    frame_buf.delete();
    ihl = $urandom_range(5, 7);
    hl = ihl * 4;
    for (int i = 0; i < 14 + hl + seg_n; i++) frame_buf.push_back(8'($urandom));
    if (kind == 3) begin
      put16(12, EtypeArp);
      frame_buf[21] = ($urandom_range(0, 1) != 0) ? 8'd1 : 8'd2;
      return;
    end
    if (kind == 4) return;
    put16(12, EtypeIpv4);
    proto = (kind == 0) ? ProtoTcp : (kind == 1) ? ProtoUdp :
            (kind == 2) ? ProtoIcmp : 8'($urandom);
    frame_buf[14] = {4'd4, 4'(ihl)};
    total = hl + seg_n;
    put16(16, 16'(total));
    frame_buf[23] = proto;
    put16(24, 16'h0000);
    put16(24, csum(14, hl, 0));
    if (kind == 0 && seg_n >= 20) begin
      put16(14 + hl + 16, 16'h0000);
      pre = 32'd6 + seg_n;
      for (int i = 26; i < 34; i += 2) pre += {frame_buf[i], frame_buf[i + 1]};
      put16(14 + hl + 16, csum(14 + hl, seg_n, pre));
    end
    if (!good) frame_buf[$urandom_range(14, frame_buf.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    // sometimes append trailing padding or cut the frame short
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 9)) frame_buf.push_back(8'($urandom));
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
  endfunction

  task automatic send_bytes(int unsigned n, logic [7:0] fill, bit rnd);
    frame_buf.delete();
    for (int unsigned i = 0; i < n; i++) frame_buf.push_back(rnd ? 8'($urandom) : fill);
    send_frame();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-byte frame, all-ones and all-zero frames.
    send_bytes(1, 8'hFF, 0);
    send_bytes(20, 8'hFF, 0);
    send_bytes(24, 8'h00, 0);
    // Zero header length with tiny segment lengths around the pseudo-header.
    for (int n = 0; n < 5; n++) begin
      frame_buf.delete();
      for (int i = 0; i < 40; i++) frame_buf.push_back(8'($urandom));
      put16(12, EtypeIpv4);
      frame_buf[14] = 8'h40;
      put16(16, 16'(n));
      frame_buf[23] = ProtoTcp;
      frame_buf = frame_buf[0 : 14 + n + (n % 2) + 3];
      send_frame();
    end
    // Total length below header length wraps the segment length.
    build_frame(0, 20, 1); put16(16, 16'd4); send_frame();
    // One of each kind, odd TCP segment, bad checksum.
    build_frame(0, 21, 1); send_frame();
    build_frame(0, 24, 0); send_frame();
    build_frame(1, 8, 1); send_frame();
    build_frame(2, 8, 1); send_frame();
    build_frame(3, 28, 1); send_frame();
    build_frame(4, 30, 1); send_frame();

    // Pressure: hold the receiver for a fixed stretch in its own process
    // while short frames keep arriving and the input stalls.
    hold_pop = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_pop = 1'b0;
      end
    join_none
    for (int i = 0; i < 8; i++) send_bytes($urandom_range(1, 3), 8'h00, 1);
    wait (!hold_pop);

    // Random frames, mostly well formed.
    while (bytes_sent < 800) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: build_frame(0, $urandom_range(20, 40), $urandom_range(0, 4) != 0);
        4, 5: build_frame(1, $urandom_range(8, 20), 1);
        6: build_frame(2, $urandom_range(4, 12), 1);
        7: build_frame(3, 28, 1);
        8: build_frame($urandom_range(4, 5), $urandom_range(0, 10), 1);
        default: begin
          frame_buf.delete();
          repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom));
        end
      endcase
      send_frame();
    end

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS ethernet_ipv4_header_parser");
    end else begin
      $display("FAIL ethernet_ipv4_header_parser");
    end
    $finish;
  end

  initial sb.clear_frame();
endmodule

// ===== files.f =====
src/eihp_pkg.sv
src/eihp_front.sv
src/eihp_queue.sv
src/eihp_back.sv
src/ethernet_ipv4_header_parser.sv
src/eihp_checker.sv
tb/tb_ethernet_ipv4_header_parser.sv
